>>> rtl/bbcw_pkg.sv
// Types and constants shared by the box blur block.
// Used by the channel interfaces and the top level; no dependencies.
`default_nettype none

package bbcw_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int PIXEL_W    = CHAN_W * NUM_CHAN;
    localparam int CFG_DIM_W  = 9;
    localparam int CFG_RAD_W  = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RESET  = 9'd256;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RESET = 9'd256;
    localparam logic [CFG_RAD_W-1:0] RADIUS_RESET = 3'd1;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_BLUR_RADIUS  = 2'd2
    } cfg_index_t;

    // red in the low byte of the stored word
    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_t;

endpackage

`default_nettype wire

>>> rtl/bbcw_if.sv
// Valid/ready channel interfaces: pixel input, blurred output, register writes.
// Depends on bbcw_pkg.
`default_nettype none

interface bbcw_in_if;
    import bbcw_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;

    modport source (output valid, kind, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface bbcw_out_if;
    import bbcw_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              last_pixel;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, last_pixel,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_pixel,
                    output ready);
endinterface

interface bbcw_cfg_if;
    import bbcw_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

>>> rtl/bbcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bbcw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output      logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/box_blur_clipped_window.sv
// Box blur over a clipped square window, frame held in one RAM.
// Load transaction: written straight into the frame RAM; the next may follow at once.
// Request transaction: reads N = in-bound window pixels (up to (2R+1)^2),
// one frame RAM read per cycle, then runs SW (16 by default) divide steps.
// Reset: positions cleared, registers at 256 x 256, radius 1; frame RAM content unknown.
// Depends on bbcw_pkg, bbcw_if, bbcw_ram.
`default_nettype none

module box_blur_clipped_window #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7
) (
    input wire logic clk,
    input wire logic rst_n,
    bbcw_in_if.sink     pixels,
    bbcw_out_if.source  blurred,
    bbcw_cfg_if.sink    cfg
);
    import bbcw_pkg::*;

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIN   = 2 * MAX_RADIUS + 1;
    localparam int CNW   = $clog2(WIN * WIN + 1);
    localparam int SW    = $clog2(WIN * WIN * ((1 << CHAN_W) - 1) + 1);
    localparam int DCW   = $clog2(SW);
    localparam int PW0   = (XW > YW) ? XW : YW;
    localparam int PW    = ((PW0 > RW) ? PW0 : RW) + 1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_DIM_W-1:0] width_reg, width_next;
    logic [CFG_DIM_W-1:0] height_reg, height_next;
    logic [CFG_RAD_W-1:0] radius_reg, radius_next;

    logic [XW-1:0] load_x_reg, load_x_next, emit_x_reg, emit_x_next;
    logic [YW-1:0] load_y_reg, load_y_next, emit_y_reg, emit_y_next;

    logic [XW-1:0] xlo_reg, xlo_next, xhi_reg, xhi_next, scan_x_reg, scan_x_next;
    logic [YW-1:0] ylo_reg, ylo_next, yhi_reg, yhi_next, scan_y_reg, scan_y_next;

    logic [SW-1:0]  sum_reg [NUM_CHAN];
    logic [SW-1:0]  sum_next [NUM_CHAN];
    logic [CNW-1:0] rem_reg [NUM_CHAN];
    logic [CNW-1:0] rem_next [NUM_CHAN];
    logic [CNW-1:0] count_reg, count_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic           last_reg, last_next;
    logic           rd_valid_reg;

    logic              out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0] out_chan_reg [NUM_CHAN];
    logic [CHAN_W-1:0] out_chan_next [NUM_CHAN];
    logic              out_last_reg, out_last_next;

    logic [XW-1:0] w_last;
    logic [YW-1:0] h_last;
    logic [RW-1:0] r_eff;

    logic          cfg_write, in_accept, out_take;
    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [PIXEL_W-1:0] rd_data;
    pixel_t        wr_pixel;

    logic [PW-1:0] cx_e, cy_e, r_e, xs, ys;
    logic [CNW:0]  shifted [NUM_CHAN];
    logic          ge [NUM_CHAN];

    // effective geometry: zero taken as one, saturate at the maxima
    always_comb
    begin
        if (width_reg == '0)
            w_last = '0;
        else if (32'(width_reg) > MAX_WIDTH)
            w_last = XW'(MAX_WIDTH - 1);
        else
            w_last = XW'(32'(width_reg) - 1);

        if (height_reg == '0)
            h_last = '0;
        else if (32'(height_reg) > MAX_HEIGHT)
            h_last = YW'(MAX_HEIGHT - 1);
        else
            h_last = YW'(32'(height_reg) - 1);

        if (32'(radius_reg) > MAX_RADIUS)
            r_eff = RW'(MAX_RADIUS);
        else
            r_eff = RW'(radius_reg);
    end

    assign cfg.ready    = 1'b1;
    // a register write offered in the same cycle takes precedence over the pixel input
    assign pixels.ready = (state_reg == ST_IDLE) && !cfg.valid;
    assign cfg_write    = cfg.valid && cfg.ready;
    assign in_accept    = pixels.valid && pixels.ready;
    assign out_take     = blurred.valid && blurred.ready;

    assign cx_e = PW'(emit_x_reg);
    assign cy_e = PW'(emit_y_reg);
    assign r_e  = PW'(r_eff);
    assign xs   = cx_e + r_e;
    assign ys   = cy_e + r_e;

    assign wr_pixel = '{alpha: pixels.alpha_in, blue: pixels.blue_in,
                        green: pixels.green_in, red: pixels.red_in};
    assign wr_en    = in_accept && (pixels.kind == KIND_LOAD);
    assign wr_addr  = AW'(32'(load_y_reg) * MAX_WIDTH + 32'(load_x_reg));
    assign rd_en    = (state_reg == ST_SCAN);
    assign rd_addr  = AW'(32'(scan_y_reg) * MAX_WIDTH + 32'(scan_x_reg));

    bbcw_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // one restoring divide step per channel, shared divisor
    always_comb
    begin
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            shifted[c] = {rem_reg[c], sum_reg[c][SW-1]};
            ge[c]      = (shifted[c] >= {1'b0, count_reg});
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        radius_next    = radius_reg;
        load_x_next    = load_x_reg;
        load_y_next    = load_y_reg;
        emit_x_next    = emit_x_reg;
        emit_y_next    = emit_y_reg;
        xlo_next       = xlo_reg;
        xhi_next       = xhi_reg;
        ylo_next       = ylo_reg;
        yhi_next       = yhi_reg;
        scan_x_next    = scan_x_reg;
        scan_y_next    = scan_y_reg;
        count_next     = count_reg;
        div_cnt_next   = div_cnt_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            sum_next[c]      = sum_reg[c];
            rem_next[c]      = rem_reg[c];
            out_chan_next[c] = out_chan_reg[c];
        end

        if (out_take)
            out_valid_next = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg.addr)
                REG_IMAGE_WIDTH:
                begin
                    width_next  = cfg.data[CFG_DIM_W-1:0];
                    load_x_next = '0;
                    load_y_next = '0;
                    emit_x_next = '0;
                    emit_y_next = '0;
                end
                REG_IMAGE_HEIGHT:
                begin
                    height_next = cfg.data[CFG_DIM_W-1:0];
                    load_x_next = '0;
                    load_y_next = '0;
                    emit_x_next = '0;
                    emit_y_next = '0;
                end
                REG_BLUR_RADIUS:
                begin
                    radius_next = cfg.data[CFG_RAD_W-1:0];
                    load_x_next = '0;
                    load_y_next = '0;
                    emit_x_next = '0;
                    emit_y_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            if (pixels.kind == KIND_LOAD)
            begin
                if (load_x_reg == w_last)
                begin
                    load_x_next = '0;
                    load_y_next = (load_y_reg == h_last) ? '0 : load_y_reg + 1'b1;
                end
                else
                begin
                    load_x_next = load_x_reg + 1'b1;
                end
            end
            else
            begin
                // window clipped to the image
                xlo_next    = (cx_e >= r_e) ? XW'(cx_e - r_e) : '0;
                ylo_next    = (cy_e >= r_e) ? YW'(cy_e - r_e) : '0;
                xhi_next    = (xs > PW'(w_last)) ? w_last : XW'(xs);
                yhi_next    = (ys > PW'(h_last)) ? h_last : YW'(ys);
                scan_x_next = xlo_next;
                scan_y_next = ylo_next;
                count_next  = '0;
                for (int c = 0; c < NUM_CHAN; c++)
                    sum_next[c] = '0;
                last_next = (emit_x_reg == w_last) && (emit_y_reg == h_last);
                if (emit_x_reg == w_last)
                begin
                    emit_x_next = '0;
                    emit_y_next = (emit_y_reg == h_last) ? '0 : emit_y_reg + 1'b1;
                end
                else
                begin
                    emit_x_next = emit_x_reg + 1'b1;
                end
                state_next = ST_SCAN;
            end
        end

        if (rd_valid_reg)
        begin
            for (int c = 0; c < NUM_CHAN; c++)
                sum_next[c] = sum_reg[c] + SW'(rd_data[c*CHAN_W +: CHAN_W]);
            count_next = count_reg + 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_SCAN:
            begin
                if (scan_x_reg == xhi_reg)
                begin
                    scan_x_next = xlo_reg;
                    if (scan_y_reg == yhi_reg)
                        state_next = ST_DRAIN;
                    else
                        scan_y_next = scan_y_reg + 1'b1;
                end
                else
                begin
                    scan_x_next = scan_x_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                for (int c = 0; c < NUM_CHAN; c++)
                    rem_next[c] = '0;
                div_cnt_next = DCW'(SW - 1);
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                for (int c = 0; c < NUM_CHAN; c++)
                begin
                    rem_next[c] = ge[c] ? CNW'(shifted[c] - {1'b0, count_reg})
                                        : CNW'(shifted[c]);
                    sum_next[c] = {sum_reg[c][SW-2:0], ge[c]};
                end
                if (div_cnt_reg == '0)
                    state_next = ST_DONE;
                else
                    div_cnt_next = div_cnt_reg - 1'b1;
            end
            ST_DONE:
            begin
                // quotient sits in the low bits of the sum register
                if (!out_valid_reg || blurred.ready)
                begin
                    for (int c = 0; c < NUM_CHAN; c++)
                        out_chan_next[c] = sum_reg[c][CHAN_W-1:0];
                    out_last_next  = last_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            radius_reg    <= RADIUS_RESET;
            load_x_reg    <= '0;
            load_y_reg    <= '0;
            emit_x_reg    <= '0;
            emit_y_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            radius_reg    <= radius_next;
            load_x_reg    <= load_x_next;
            load_y_reg    <= load_y_next;
            emit_x_reg    <= emit_x_next;
            emit_y_reg    <= emit_y_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xlo_reg      <= xlo_next;
        xhi_reg      <= xhi_next;
        ylo_reg      <= ylo_next;
        yhi_reg      <= yhi_next;
        scan_x_reg   <= scan_x_next;
        scan_y_reg   <= scan_y_next;
        count_reg    <= count_next;
        div_cnt_reg  <= div_cnt_next;
        last_reg     <= last_next;
        out_last_reg <= out_last_next;
        for (int c = 0; c < NUM_CHAN; c++)
        begin
            sum_reg[c]      <= sum_next[c];
            rem_reg[c]      <= rem_next[c];
            out_chan_reg[c] <= out_chan_next[c];
        end
    end

    assign blurred.valid      = out_valid_reg;
    assign blurred.red_out    = out_chan_reg[0];
    assign blurred.green_out  = out_chan_reg[1];
    assign blurred.blue_out   = out_chan_reg[2];
    assign blurred.alpha_out  = out_chan_reg[3];
    assign blurred.last_pixel = out_last_reg;

    // scan address stays inside the clipped window
    a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_x_reg >= xlo_reg) && (scan_x_reg <= xhi_reg)
                                   && (scan_y_reg >= ylo_reg) && (scan_y_reg <= yhi_reg))
        else $error("scan address outside window");

    // the centre pixel is always read, so the divisor is never zero
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIVIDE) |-> (count_reg != '0))
        else $error("zero divisor");

    // a mean never exceeds one channel
    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (sum_reg[0][SW-1:CHAN_W] == '0)
                                   && (sum_reg[1][SW-1:CHAN_W] == '0)
                                   && (sum_reg[2][SW-1:CHAN_W] == '0)
                                   && (sum_reg[3][SW-1:CHAN_W] == '0))
        else $error("quotient overflow");

    // positions stay inside the frame in use
    a_positions_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (load_x_reg <= w_last) && (load_y_reg <= h_last)
                 && (emit_x_reg <= w_last) && (emit_y_reg <= h_last))
        else $error("position outside frame");

endmodule

`default_nettype wire
